>>> hdl/aht_pkg.sv
package aht_pkg;

  localparam int MAX_SLOTS_DEF = 256;
  localparam int KEY_W         = 32;
  localparam int ORDER_W       = 8;
  localparam int TSIZE_W       = 9;
  localparam int COUNT_W       = 9;
  localparam int STATUS_W      = 3;
  localparam logic [TSIZE_W-1:0] TSIZE_RST = 9'd256;

  // remainder unit: bits of the address folded in per cycle
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = KEY_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ZERO     = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    clear_wr;
    logic    load;
    logic    mod_step;
    logic    rd_en;
    logic    ins_wr;
    logic    advance;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } aht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic addr_zero;
    logic tbl_full;
    logic is_lookup;
    logic key_empty;
    logic key_match;
    logic last_probe;
    logic out_busy;
  } aht_stat_t;

endpackage

>>> hdl/address_hash_table.sv
// Address hash table: open addressing with linear probing over 32-bit keys.
// Request channel (in_valid/in_ready): action 0 inserts addr, 1 looks it up.
// Result channel (out_valid/out_ready): status and order_index, one result per
// request, in request order. cfg_wr_en/cfg_wr_data set table_size (slots in
// use, 0 acts as 1, above MAX_SLOTS acts as MAX_SLOTS); write it only idle.
// One request at a time. After acceptance the home slot (addr mod size) comes
// from a remainder unit taking 4 address bits a cycle. Each probe is a
// key-store read (S_READ) then a compare (S_CHECK); in_ready rises again once
// the result is handed to the output register. Rejected zero addresses, zero
// lookups and full-table inserts skip the remainder and probe steps. The result
// turns valid in the same cycle that in_ready rises.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver still stalls when the following result is done,
// the block holds that result and keeps in_ready low until the register frees.
// Reset (synchronous) zeroes the entry count, sets table_size to 256 and runs
// a clearing sweep of the key store, one slot per cycle, during which
// in_ready stays low. Configuration writes are taken throughout.
module address_hash_table #(
  parameter int MAX_SLOTS = aht_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [aht_pkg::TSIZE_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic [aht_pkg::KEY_W-1:0]    addr,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [aht_pkg::STATUS_W-1:0] status,
  output logic [aht_pkg::ORDER_W-1:0]  order_index
);
  import aht_pkg::*;

  aht_cmd_t  cmd;   // controller commands
  aht_stat_t stat;  // datapath flags

  // sequencer: clear sweep, remainder steps, probe loop, result hand-off
  aht_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .stat    (stat)
  );

  // key/order store, remainder unit, probe pointer, entry count, output regs
  aht_dp #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .action     (action),
    .addr       (addr),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .status     (status),
    .order_index(order_index)
  );

endmodule

>>> hdl/aht_ram.sv
module aht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/aht_ctrl.sv
module aht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output aht_pkg::aht_cmd_t  cmd,
  input  aht_pkg::aht_stat_t stat
);
  import aht_pkg::*;

  localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [MOD_CNT_W-1:0] mod_cnt, mod_cnt_next;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    mod_cnt_next = mod_cnt;
    in_ready     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          mod_cnt_next = '0;
          state_next   = S_MOD;
        end
      end
      S_MOD: begin
        priority if (mod_cnt == '0 && stat.addr_zero) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = stat.is_lookup ? ST_NOTFOUND : ST_ZERO;
          state_next   = S_DONE;
        end else if (mod_cnt == '0 && !stat.is_lookup && stat.tbl_full) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_FULL;
          state_next   = S_DONE;
        end else begin
          cmd.mod_step = 1'b1;
          if (mod_cnt == MOD_LAST) begin
            mod_cnt_next = '0;
            state_next   = S_READ;
          end else begin
            mod_cnt_next = mod_cnt + MOD_CNT_W'(1);
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat.key_empty) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = stat.is_lookup ? ST_NOTFOUND : ST_OK;
          cmd.ins_wr   = !stat.is_lookup;
          state_next   = S_DONE;
        end else if (stat.key_match) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = stat.is_lookup ? ST_OK : ST_DUP;
          state_next   = S_DONE;
        end else if (stat.last_probe) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = stat.is_lookup ? ST_NOTFOUND : ST_FULL;
          state_next   = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      mod_cnt <= '0;
    end else begin
      state   <= state_next;
      mod_cnt <= mod_cnt_next;
    end
  end

  a_reset_blocks_input: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken right after reset");

  a_insert_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |-> (stat.key_empty && !stat.is_lookup && !stat.tbl_full))
    else $error("insert write into occupied slot or full table");

  a_hit_needs_match: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_set && cmd.res_code == ST_OK && stat.is_lookup) |-> stat.key_match)
    else $error("lookup hit without key match");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_busy)
    else $error("result register overwritten");

endmodule

>>> hdl/aht_dp.sv
module aht_dp #(
  parameter int MAX_SLOTS = aht_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [aht_pkg::TSIZE_W-1:0]   cfg_wr_data,
  input  logic                          action,
  input  logic [aht_pkg::KEY_W-1:0]     addr,
  input  aht_pkg::aht_cmd_t             cmd,
  output aht_pkg::aht_stat_t            stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [aht_pkg::STATUS_W-1:0]  status,
  output logic [aht_pkg::ORDER_W-1:0]   order_index
);
  import aht_pkg::*;

  localparam int ADDR_W = $clog2(MAX_SLOTS);
  localparam int IDX_W  = (ADDR_W > TSIZE_W) ? ADDR_W : TSIZE_W;
  localparam int RAM_W  = KEY_W + ORDER_W;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_SLOTS - 1);

  logic [TSIZE_W-1:0] table_size;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [COUNT_W-1:0] count;

  logic               is_lookup;
  logic [KEY_W-1:0]   key;
  logic [KEY_W-1:0]   key_sh;
  logic [IDX_W-1:0]   size;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   probes_left;
  status_t            res_status;
  logic [ORDER_W-1:0] res_order;
  status_t            out_status;
  logic [ORDER_W-1:0] out_order;

  logic [IDX_W-1:0]   size_use;
  logic [IDX_W:0]     rem;
  logic [IDX_W-1:0]   slot_inc;
  logic [IDX_W-1:0]   slot_next;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [RAM_W-1:0]   ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [ORDER_W-1:0] rd_order;

  // clamp the register to 1..MAX_SLOTS
  always_comb begin
    if (table_size == '0) begin
      size_use = IDX_W'(1);
    end else if (32'(table_size) > MAX_SLOTS) begin
      size_use = IDX_W'(MAX_SLOTS);
    end else begin
      size_use = IDX_W'(table_size);
    end
  end

  // restoring remainder, MOD_BITS address bits per step, msb first
  always_comb begin
    rem = {1'b0, slot};
    for (int i = 0; i < MOD_BITS; i++) begin
      rem = {rem[IDX_W-1:0], key_sh[KEY_W-1-i]};
      if (rem >= {1'b0, size}) begin
        rem = rem - {1'b0, size};
      end
    end
  end

  assign slot_inc  = slot + IDX_W'(1);
  assign slot_next = (slot_inc == size) ? '0 : slot_inc;

  assign ram_we    = cmd.clear_wr | cmd.ins_wr;
  assign ram_waddr = cmd.clear_wr ? clr_cnt : slot[ADDR_W-1:0];
  assign ram_wdata = cmd.clear_wr ? '0 : {key, count[ORDER_W-1:0]};
  assign rd_key    = ram_rdata[RAM_W-1:ORDER_W];
  assign rd_order  = ram_rdata[ORDER_W-1:0];

  aht_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(slot[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TSIZE_RST;
      clr_cnt    <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_size <= cfg_wr_data;
      end
      if (cmd.clear_wr) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (cmd.ins_wr) begin
        count <= count + COUNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_lookup   <= (action == ACT_LOOKUP);
      key         <= addr;
      key_sh      <= addr;
      size        <= size_use;
      slot        <= '0;
      probes_left <= size_use;
    end
    if (cmd.mod_step) begin
      key_sh <= key_sh << MOD_BITS;
      slot   <= rem[IDX_W-1:0];
    end
    if (cmd.advance) begin
      slot        <= slot_next;
      probes_left <= probes_left - IDX_W'(1);
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      if (cmd.res_code == ST_OK) begin
        res_order <= is_lookup ? rd_order : count[ORDER_W-1:0];
      end else begin
        res_order <= '0;
      end
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_order  <= res_order;
    end
  end

  assign status      = out_status;
  assign order_index = out_order;

  assign stat.clear_last = (clr_cnt == CLR_LAST);
  assign stat.addr_zero  = (key == '0);
  assign stat.tbl_full   = (IDX_W'(count) >= size);
  assign stat.is_lookup  = is_lookup;
  assign stat.key_empty  = (rd_key == '0);
  assign stat.key_match  = (rd_key == key);
  assign stat.last_probe = (probes_left == IDX_W'(1));
  assign stat.out_busy   = out_valid & ~out_ready;

endmodule

>>> bench/aht_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the size register, keeps a shadow of the table
// and compares every result with the answer it predicts.
module aht_checker #(
  parameter int MAX_SLOTS = aht_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [aht_pkg::TSIZE_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         action,
  input  logic [aht_pkg::KEY_W-1:0]    addr,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [aht_pkg::STATUS_W-1:0] status,
  input  logic [aht_pkg::ORDER_W-1:0]  order_index,
  output int                           mismatches,
  output int                           results_owed
);

  import aht_pkg::*;

  typedef struct packed {
    status_t              code;
    logic [ORDER_W-1:0]   order;
  } hash_answer_t;

  logic [KEY_W-1:0]   slot_key   [MAX_SLOTS];
  logic [ORDER_W-1:0] slot_order [MAX_SLOTS];
  logic [COUNT_W-1:0] stored_entries;
  logic [TSIZE_W-1:0] size_reg;
  hash_answer_t       answers_due [$];

  initial begin
    mismatches   = 0;
    results_owed = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns hash table check: %s", $time, msg);
    mismatches++;
  endtask

  // Shadow of one request: updates the table copy and returns the answer.
  function automatic hash_answer_t apply_request(input logic act, input logic [KEY_W-1:0] a);
    hash_answer_t ans;
    int unsigned  span;
    int unsigned  slot;
    bit           done;
    span = (size_reg == 0) ? 1 : ((size_reg > MAX_SLOTS) ? MAX_SLOTS : size_reg);
    ans.code  = ST_NOTFOUND;
    ans.order = '0;
    done      = 1'b0;
    if (act == ACT_INSERT) begin
      if (a == '0) begin
        ans.code = ST_ZERO;
      end else if (stored_entries >= span) begin
        ans.code = ST_FULL;  // presence is not checked first
      end else begin
        ans.code = ST_FULL;
        slot = a % span;
        for (int n = 0; n < span && !done; n++) begin
          if (slot_key[slot] == '0) begin
            slot_key[slot]   = a;
            ans.order        = stored_entries[ORDER_W-1:0];
            slot_order[slot] = ans.order;
            stored_entries++;
            ans.code = ST_OK;
            done     = 1'b1;
          end else if (slot_key[slot] == a) begin
            ans.code = ST_DUP;
            done     = 1'b1;
          end else begin
            slot = (slot + 1 == span) ? 0 : slot + 1;
          end
        end
      end
    end else if (a != '0) begin
      slot = a % span;
      for (int n = 0; n < span && !done; n++) begin
        if (slot_key[slot] == '0) begin
          done = 1'b1;
        end else if (slot_key[slot] == a) begin
          ans.order = slot_order[slot];
          ans.code  = ST_OK;
          done      = 1'b1;
        end else begin
          slot = (slot + 1 == span) ? 0 : slot + 1;
        end
      end
    end
    if (ans.code != ST_OK) ans.order = '0;
    return ans;
  endfunction

  always @(posedge clk) begin
    hash_answer_t due;
    if (rst) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_key[i]   = '0;
        slot_order[i] = '0;
      end
      stored_entries = '0;
      size_reg       = TSIZE_RST;
      answers_due.delete();
    end else begin
      if (cfg_wr_en) size_reg = cfg_wr_data;
      if (in_valid && in_ready) answers_due.push_back(apply_request(action, addr));
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting (status %0d order %0d)",
                                    status, order_index));
        end else begin
          due = answers_due.pop_front();
          if (status !== due.code)
            report_mismatch($sformatf("status %0d, want %0d", status, due.code));
          if (order_index !== due.order)
            report_mismatch($sformatf("order_index %0d, want %0d", order_index, due.order));
        end
      end
    end
    results_owed <= answers_due.size();
  end

endmodule

>>> bench/tb_address_hash_table.sv
`timescale 1ns / 1ps

// Top of the hash table bench. Drives requests and table size writes, stalls
// the result side at random and gives the verdict; all prediction and
// comparison lives in aht_checker.
module tb_address_hash_table;

  import aht_pkg::*;

  localparam int MAX_SLOTS = MAX_SLOTS_DEF;

  // Worst request: a probe chain over all MAX_SLOTS slots, plus the longest send
  // gap and the longest receiver stall; ~710 requests of that, plus the reset
  // clearing sweep, give the worst run. Limit is about four times that.
  localparam int CYCLE_LIMIT = 2_000_000;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_wr_en    = 1'b0;
  logic [TSIZE_W-1:0]  cfg_wr_data  = '0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                action       = ACT_INSERT;
  logic [KEY_W-1:0]    addr         = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ORDER_W-1:0]  order_index;

  int                  mismatches;
  int                  results_owed;
  int                  cycle_count  = 0;
  bit                  calm         = 1'b0;  // no idling on either side
  logic [KEY_W-1:0]    addr_pool [$];       // nonzero keys sent for insert so far

  always #4 clk = ~clk;

  address_hash_table #(.MAX_SLOTS(MAX_SLOTS)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .addr        (addr),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .order_index (order_index)
  );

  aht_checker #(.MAX_SLOTS(MAX_SLOTS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .addr         (addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .order_index  (order_index),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Key mix: home-slot collisions to build probe chains, keys already sent
  // (hits and duplicates), the extreme values, and fully random words.
  function automatic logic [KEY_W-1:0] pick_addr(input int unsigned span);
    int               roll;
    logic [KEY_W-1:0] a;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      a = $urandom_range(1, 4000) * span + $urandom_range(0, (span > 4) ? 3 : span - 1);
    end else if (roll < 65 && addr_pool.size() > 0) begin
      a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    end else if (roll < 72) begin
      case ($urandom_range(0, 3))
        0:       a = '0;
        1:       a = 32'h0000_0001;
        2:       a = '1;
        default: a = 32'h8000_0000;
      endcase
    end else begin
      a = $urandom;
    end
    return a;
  endfunction

  // Request side. A zero gap keeps in_valid high straight into the next
  // request, so valid is never lowered and raised in the same step.
  task automatic send_request(input logic act, input logic [KEY_W-1:0] a);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action   <= act;
    addr     <= a;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Every request yields a result, so an empty result queue means idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic set_table_size(input logic [TSIZE_W-1:0] size_val);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size_val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(input logic [TSIZE_W-1:0] size_val, input int n_items);
    int unsigned      span;
    int               insert_pct;
    logic             act;
    logic [KEY_W-1:0] a;
    set_table_size(size_val);
    span       = (size_val == 0) ? 1 : ((size_val > MAX_SLOTS) ? MAX_SLOTS : size_val);
    insert_pct = $urandom_range(40, 75);
    for (int i = 0; i < n_items; i++) begin
      act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_LOOKUP;
      a   = pick_addr(span);
      if (act == ACT_INSERT && a != '0) addr_pool.push_back(a);
      send_request(act, a);
    end
  endtask

  // Result side: ready for a while, then a stall, unless in a calm stretch.
  always begin : result_stalls
    int stall;
    out_ready <= 1'b1;
    repeat (1 + idle_len()) @(posedge clk);
    if (!calm) begin
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[address_hash_table] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    // -1 picks a random size; sizes mostly grow so the table fills gradually,
    // with a few drops below the entry count.
    int phase_size [17] = '{2, 9, 16, 17, 40, 1, 64, 100, -1, 128, -1, 200, 0,
                            255, 256, 511, -1};
    logic [TSIZE_W-1:0] size_val;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, first at the reset size of 256 (no write yet).
    send_request(ACT_LOOKUP, '0);             // zero lookup on empty table
    send_request(ACT_INSERT, '0);             // zero insert rejected
    send_request(ACT_LOOKUP, 32'd5);          // miss at an empty home slot
    send_request(ACT_INSERT, '1);             // top key lands in the last slot
    send_request(ACT_INSERT, 32'd255);        // same home, wraps to slot 0
    send_request(ACT_INSERT, 32'd1);
    send_request(ACT_INSERT, 32'd256);        // home 0, probes to slot 2
    send_request(ACT_LOOKUP, 32'd256);        // hit after probing
    send_request(ACT_LOOKUP, '1);
    send_request(ACT_INSERT, 32'd255);        // duplicate
    send_request(ACT_LOOKUP, 32'd511);        // probe chain ends at empty slot
    send_request(ACT_INSERT, 32'h8000_0000);

    // Single slot: count already above size, so inserts are full even for a
    // key that is present; lookup probing stops after one slot.
    set_table_size(9'd1);
    send_request(ACT_INSERT, 32'd7);
    send_request(ACT_INSERT, 32'd255);
    send_request(ACT_LOOKUP, 32'd255);
    send_request(ACT_LOOKUP, '1);

    set_table_size(9'd0);                     // acts as one slot
    send_request(ACT_LOOKUP, 32'd255);

    set_table_size(9'd511);                   // acts as MAX_SLOTS
    send_request(ACT_LOOKUP, 32'd256);
    send_request(ACT_INSERT, 32'd2);

    // Shrunk below the filled range: upper entries are hidden but counted.
    set_table_size(9'd3);
    send_request(ACT_INSERT, 32'd11);
    send_request(ACT_LOOKUP, 32'd256);
    send_request(ACT_LOOKUP, '1);             // all three slots taken, no match

    for (int p = 0; p < 17; p++) begin
      calm     = (p % 3 == 2);
      size_val = (phase_size[p] < 0) ? TSIZE_W'($urandom_range(1, MAX_SLOTS))
                                     : TSIZE_W'(phase_size[p]);
      run_phase(size_val, 40);
    end
    calm = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[address_hash_table] OK");
    end else begin
      $display("[address_hash_table] ERROR");
    end
    $finish;
  end

endmodule
